// ===== design/single_wire_link_responder_assert.svh =====
// Assertion macros shared by the checker of the link responder.
`ifndef SINGLE_WIRE_LINK_RESPONDER_ASSERT_SVH
`define SINGLE_WIRE_LINK_RESPONDER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/slr_pkg.sv =====
// Types and constants shared by the link responder modules.
`default_nettype none
package slr_pkg;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_TX_DONE = 2'd1,
        OP_POST    = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SEND   = 2'd1,
        ACT_STREAM = 2'd2,
        ACT_STORE  = 2'd3
    } t_action;

    localparam logic [7:0] FLOW_M2S    = 8'hF0;
    localparam logic [7:0] FLOW_S2M    = 8'hF1;
    localparam logic [7:0] CONTENT_CMD = 8'hC0;
    localparam logic [7:0] ID_CMD      = 8'hC1;
    localparam logic [7:0] ID_LOG      = 8'hC0;
    localparam logic [7:0] ID_PROC     = 8'hC2;
    localparam logic [7:0] ID_NONE     = 8'h00;

    localparam int CMD_INDEX_W = 6;

    // One classified word as it waits between the front and the back.
    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic [2:0] post_mask;
        logic       is_flow_m2s;
        logic       is_flow_s2m;
        logic       is_content_cmd;
        logic       is_zero;
    } t_item;

endpackage
`default_nettype wire

// ===== design/slr_front.sv =====
// Input side: accepts words, classifies them and queues them for the back end.
`default_nettype none
module slr_front import slr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [2:0] i_post_mask,
    output t_item           o_item,
    output logic            o_item_valid,
    input  wire logic       i_item_pop
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    t_item       n_item;
    logic        push;

    always_comb begin
        n_item.op             = t_op'(i_operation);
        n_item.rx_byte        = i_rx_byte;
        n_item.post_mask      = i_post_mask;
        n_item.is_flow_m2s    = (i_rx_byte == FLOW_M2S);
        n_item.is_flow_s2m    = (i_rx_byte == FLOW_S2M);
        n_item.is_content_cmd = (i_rx_byte == CONTENT_CMD);
        n_item.is_zero        = (i_rx_byte == 8'h00);
    end

    assign o_in_stall   = r_count[1];
    assign push         = i_in_valid && !o_in_stall;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_item_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({push, i_item_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/slr_back.sv =====
// Back end: link state machine that carries out queued words into the result register.
`default_nettype none
module slr_back import slr_pkg::*; #(
    parameter int CMD_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_item      i_item,
    input  wire logic       i_item_valid,
    output logic            o_item_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_action,
    output logic [7:0]      o_tx_byte,
    output logic [1:0]      o_buffer_sel,
    output logic [5:0]      o_cmd_index,
    output logic [7:0]      o_cmd_byte,
    output logic            o_cmd_done,
    output logic [2:0]      o_out_pending,
    output logic            o_in_cmd_full
);

    localparam int IW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(CMD_DEPTH - 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ID_WAIT,
        PH_DATA_WAIT,
        PH_CONTENT,
        PH_CMD
    } t_phase;

    t_phase                  r_phase,  n_phase;
    logic [IW-1:0]           r_widx,   n_widx;
    logic [2:0]              r_flags,  n_flags;
    logic                    r_full,   n_full;
    logic [1:0]              r_chosen, n_chosen;
    logic                    r_out_valid;
    t_action                 r_action, n_action;
    logic [7:0]              r_tx,     n_tx;
    logic [1:0]              r_sel,    n_sel;
    logic [5:0]              r_idx,    n_idx;
    logic [7:0]              r_cbyte,  n_cbyte;
    logic                    r_done,   n_done;
    logic                    at_last;
    logic [IW+CMD_INDEX_W-1:0] widx_ext;

    assign o_item_pop = i_item_valid && (!r_out_valid || !i_out_stall);
    assign at_last    = (r_widx == LAST_SLOT);
    assign widx_ext   = {{CMD_INDEX_W{1'b0}}, r_widx};

    always_comb begin
        n_phase  = r_phase;
        n_widx   = r_widx;
        n_flags  = r_flags;
        n_full   = r_full;
        n_chosen = r_chosen;
        n_action = ACT_NONE;
        n_tx     = 8'h00;
        n_sel    = 2'd0;
        n_idx    = 6'd0;
        n_cbyte  = 8'h00;
        n_done   = 1'b0;
        unique case (i_item.op)
            OP_POST: begin
                n_flags = r_flags | i_item.post_mask;
            end
            OP_RELEASE: begin
                n_full = 1'b0;
            end
            OP_TX_DONE: begin
                if (r_phase == PH_ID_WAIT) begin
                    if (r_chosen == 2'd0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_action = ACT_STREAM;
                        n_sel    = r_chosen - 2'd1;
                        n_phase  = PH_DATA_WAIT;
                    end
                end else if (r_phase == PH_DATA_WAIT) begin
                    if (r_chosen != 2'd0) begin
                        n_flags = r_flags & ~(3'b001 << (r_chosen - 2'd1));
                    end
                    n_phase = PH_IDLE;
                end
            end
            OP_RX_BYTE: begin
                unique case (r_phase)
                    PH_ID_WAIT, PH_DATA_WAIT: begin
                        // Bytes that arrive while a transmit is under way are dropped.
                    end
                    PH_CONTENT: begin
                        n_widx  = '0;
                        n_phase = i_item.is_content_cmd ? PH_CMD : PH_IDLE;
                    end
                    PH_CMD: begin
                        if (r_full) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_action = ACT_STORE;
                            n_idx    = widx_ext[CMD_INDEX_W-1:0];
                            n_cbyte  = at_last ? 8'h00 : i_item.rx_byte;
                            n_widx   = r_widx + 1'b1;
                            // The last slot always terminates the command.
                            if (at_last || i_item.is_zero) begin
                                n_done  = 1'b1;
                                n_full  = 1'b1;
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (i_item.is_flow_m2s) begin
                            n_phase = PH_CONTENT;
                        end else if (i_item.is_flow_s2m) begin
                            priority if (r_flags[0]) begin
                                n_chosen = 2'd1;
                                n_tx     = ID_CMD;
                            end else if (r_flags[1]) begin
                                n_chosen = 2'd2;
                                n_tx     = ID_LOG;
                            end else if (r_flags[2]) begin
                                n_chosen = 2'd3;
                                n_tx     = ID_PROC;
                            end else begin
                                n_chosen = 2'd0;
                                n_tx     = ID_NONE;
                            end
                            n_action = ACT_SEND;
                            n_phase  = PH_ID_WAIT;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_widx      <= '0;
            r_flags     <= 3'b000;
            r_full      <= 1'b0;
            r_chosen    <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_item_pop) begin
                r_phase     <= n_phase;
                r_widx      <= n_widx;
                r_flags     <= n_flags;
                r_full      <= n_full;
                r_chosen    <= n_chosen;
                r_action    <= n_action;
                r_tx        <= n_tx;
                r_sel       <= n_sel;
                r_idx       <= n_idx;
                r_cbyte     <= n_cbyte;
                r_done      <= n_done;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The state only moves with a new result, so it matches the held word.
    assign o_out_valid   = r_out_valid;
    assign o_action      = r_action;
    assign o_tx_byte     = r_tx;
    assign o_buffer_sel  = r_sel;
    assign o_cmd_index   = r_idx;
    assign o_cmd_byte    = r_cbyte;
    assign o_cmd_done    = r_done;
    assign o_out_pending = r_flags;
    assign o_in_cmd_full = r_full;

endmodule
`default_nettype wire

// ===== design/single_wire_link_responder.sv =====
// A word accepted into the queue is registered there, then moves to the output register when not stalled.
// Throughput: one word per cycle when not stalled; a two-word queue separates intake from the link state machine.
// The output register holds a result while stalled and the queue keeps accepting until full.
// Reset (synchronous, active low) empties the queue and output register, sets the link idle,
// clears the pending flags, the command-full flag and the store position.
`default_nettype none
module single_wire_link_responder import slr_pkg::*; #(
    parameter int CMD_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [2:0] i_post_mask,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_action,
    output logic [7:0]      o_tx_byte,
    output logic [1:0]      o_buffer_sel,
    output logic [5:0]      o_cmd_index,
    output logic [7:0]      o_cmd_byte,
    output logic            o_cmd_done,
    output logic [2:0]      o_out_pending,
    output logic            o_in_cmd_full
);

    t_item item;
    logic  item_valid;
    logic  item_pop;

    slr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_rx_byte    (i_rx_byte),
        .i_post_mask  (i_post_mask),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    slr_back #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item),
        .i_item_valid  (item_valid),
        .o_item_pop    (item_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_action      (o_action),
        .o_tx_byte     (o_tx_byte),
        .o_buffer_sel  (o_buffer_sel),
        .o_cmd_index   (o_cmd_index),
        .o_cmd_byte    (o_cmd_byte),
        .o_cmd_done    (o_cmd_done),
        .o_out_pending (o_out_pending),
        .o_in_cmd_full (o_in_cmd_full)
    );

endmodule
`default_nettype wire

// ===== design/slr_checker.sv =====
// Port-level checker for the link responder and its bind to the top level.
`default_nettype none
`include "single_wire_link_responder_assert.svh"
module slr_checker import slr_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [1:0] o_action,
    input wire logic [7:0] o_tx_byte,
    input wire logic [1:0] o_buffer_sel,
    input wire logic [5:0] o_cmd_index,
    input wire logic [7:0] o_cmd_byte,
    input wire logic       o_cmd_done,
    input wire logic       o_in_cmd_full
);

    // A word with no action carries nothing but the flags.
    `SLR_ASSERT_NOW(a_none_is_empty, o_out_valid && (o_action == ACT_NONE), (o_tx_byte == 8'h00) && (o_buffer_sel == 2'd0) && (o_cmd_index == 6'd0) && (o_cmd_byte == 8'h00) && !o_cmd_done, "no-action word carries payload")

    // A finished command is a stored zero and leaves the store full.
    `SLR_ASSERT_NOW(a_done_is_zero_store, o_out_valid && o_cmd_done, (o_action == ACT_STORE) && (o_cmd_byte == 8'h00) && o_in_cmd_full, "command end is not a stored zero")

    // Only the three buffers can be streamed.
    `SLR_ASSERT_NOW(a_stream_sel_range, o_out_valid && (o_action == ACT_STREAM), o_buffer_sel != 2'd3, "stream of unknown buffer")

    // A stalled result word stays in place.
    `SLR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_action) && $stable(o_cmd_byte) && $stable(o_tx_byte), "stalled result word changed")

endmodule

bind single_wire_link_responder slr_checker u_slr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_action      (o_action),
    .o_tx_byte     (o_tx_byte),
    .o_buffer_sel  (o_buffer_sel),
    .o_cmd_index   (o_cmd_index),
    .o_cmd_byte    (o_cmd_byte),
    .o_cmd_done    (o_cmd_done),
    .o_in_cmd_full (o_in_cmd_full)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the link responder: a directed table, then random link transfers checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import slr_pkg::*;

    localparam int LINK_CMD_DEPTH = 64;
    localparam int RANDOM_WORDS   = 1600;
    localparam int DRAIN_LIMIT    = 20000;

    // Buffer chosen for a slave-to-master transfer.
    localparam logic [1:0] CHOSEN_NONE = 2'd0;
    localparam logic [1:0] CHOSEN_CMD  = 2'd1;
    localparam logic [1:0] CHOSEN_LOG  = 2'd2;
    localparam logic [1:0] CHOSEN_PROC = 2'd3;

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_ID_WAIT,
        LINK_DATA_WAIT,
        LINK_CONTENT,
        LINK_CMD
    } t_link_phase;

    typedef struct packed {
        t_action    action;
        logic [7:0] tx_byte;
        logic [1:0] buffer_sel;
        logic [5:0] cmd_index;
        logic [7:0] cmd_byte;
        logic       cmd_done;
        logic [2:0] pending;
        logic       cmd_full;
    } t_link_res;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic [2:0] post_mask;
        logic       typed;
        t_link_res  res;
    } t_dir_row;

    localparam t_link_res LINK_RES_NONE = '0;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [1:0] i_operation = 2'd0;
    logic [7:0] i_rx_byte = 8'h00;
    logic [2:0] i_post_mask = 3'd0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_action;
    logic [7:0] o_tx_byte;
    logic [1:0] o_buffer_sel;
    logic [5:0] o_cmd_index;
    logic [7:0] o_cmd_byte;
    logic       o_cmd_done;
    logic [2:0] o_out_pending;
    logic       o_in_cmd_full;

    single_wire_link_responder #(
        .CMD_DEPTH(LINK_CMD_DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_operation(i_operation),
        .i_rx_byte(i_rx_byte),
        .i_post_mask(i_post_mask),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_action(o_action),
        .o_tx_byte(o_tx_byte),
        .o_buffer_sel(o_buffer_sel),
        .o_cmd_index(o_cmd_index),
        .o_cmd_byte(o_cmd_byte),
        .o_cmd_done(o_cmd_done),
        .o_out_pending(o_out_pending),
        .o_in_cmd_full(o_in_cmd_full)
    );

    always #4 i_clk = ~i_clk;

    // Predicted link state.
    t_link_phase link_phase = LINK_IDLE;
    int          store_pos = 0;
    logic [2:0]  pend_flags = 3'd0;
    logic        cmd_full = 1'b0;
    logic [1:0]  chosen_buf = CHOSEN_NONE;

    t_link_res expected_q[$];
    int        mismatch_count = 0;
    int        words_sent = 0;
    int        burst_left = 0;
    bit        gap_on = 1'b1;

    t_dir_row dir_rows [0:24] = '{
        '{OP_RELEASE, 8'h00, 3'd0, 1'b1,
          '{ACT_NONE, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0, 3'd0, 1'b0}},
        '{OP_RX_BYTE, FLOW_S2M, 3'd0, 1'b1,
          '{ACT_SEND, ID_NONE, 2'd0, 6'd0, 8'h00, 1'b0, 3'd0, 1'b0}},
        '{OP_TX_DONE, 8'hFF, 3'd7, 1'b1,
          '{ACT_NONE, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0, 3'd0, 1'b0}},
        '{OP_TX_DONE, 8'h00, 3'd0, 1'b1,
          '{ACT_NONE, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0, 3'd0, 1'b0}},
        '{OP_POST, 8'hFF, 3'd7, 1'b1,
          '{ACT_NONE, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0, 3'd7, 1'b0}},
        '{OP_RX_BYTE, 8'h55, 3'd2, 1'b0, LINK_RES_NONE},
        '{OP_RX_BYTE, FLOW_S2M, 3'd5, 1'b1,
          '{ACT_SEND, ID_CMD, 2'd0, 6'd0, 8'h00, 1'b0, 3'd7, 1'b0}},
        '{OP_RX_BYTE, 8'hFF, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_TX_DONE, 8'h00, 3'd0, 1'b1,
          '{ACT_STREAM, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0, 3'd7, 1'b0}},
        '{OP_RX_BYTE, 8'h00, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_TX_DONE, 8'hAA, 3'd1, 1'b1,
          '{ACT_NONE, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0, 3'd6, 1'b0}},
        '{OP_RX_BYTE, FLOW_S2M, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_TX_DONE, 8'h00, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_TX_DONE, 8'h00, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_RX_BYTE, FLOW_M2S, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_RX_BYTE, 8'h12, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_RX_BYTE, FLOW_M2S, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_RX_BYTE, CONTENT_CMD, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_RX_BYTE, 8'hFF, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_RX_BYTE, 8'h00, 3'd7, 1'b1,
          '{ACT_STORE, 8'h00, 2'd0, 6'd1, 8'h00, 1'b1, 3'd4, 1'b1}},
        '{OP_RX_BYTE, FLOW_M2S, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_RX_BYTE, CONTENT_CMD, 3'd0, 1'b0, LINK_RES_NONE},
        '{OP_RX_BYTE, 8'h33, 3'd0, 1'b1,
          '{ACT_NONE, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0, 3'd4, 1'b1}},
        '{OP_RELEASE, 8'h00, 3'd7, 1'b1,
          '{ACT_NONE, 8'h00, 2'd0, 6'd0, 8'h00, 1'b0, 3'd4, 1'b0}},
        '{OP_POST, 8'h00, 3'd0, 1'b0, LINK_RES_NONE}
    };

    function automatic t_link_res link_predict(t_op op, logic [7:0] rx, logic [2:0] mask);
        t_link_res  r;
        logic [7:0] b;
        r = LINK_RES_NONE;
        case (op)
            OP_POST: pend_flags = pend_flags | mask;
            OP_RELEASE: cmd_full = 1'b0;
            OP_TX_DONE: begin
                if (link_phase == LINK_ID_WAIT) begin
                    if (chosen_buf == CHOSEN_NONE) begin
                        link_phase = LINK_IDLE;
                    end else begin
                        r.action = ACT_STREAM;
                        r.buffer_sel = chosen_buf - 2'd1;
                        link_phase = LINK_DATA_WAIT;
                    end
                end else if (link_phase == LINK_DATA_WAIT) begin
                    if (chosen_buf != CHOSEN_NONE)
                        pend_flags[chosen_buf - 2'd1] = 1'b0;
                    link_phase = LINK_IDLE;
                end
            end
            default: begin
                case (link_phase)
                    LINK_ID_WAIT, LINK_DATA_WAIT: ;
                    LINK_CONTENT: begin
                        store_pos = 0;
                        link_phase = (rx == CONTENT_CMD) ? LINK_CMD : LINK_IDLE;
                    end
                    LINK_CMD: begin
                        if (cmd_full) begin
                            link_phase = LINK_IDLE;
                        end else begin
                            // The last slot of the store always terminates the command.
                            b = (store_pos >= LINK_CMD_DEPTH - 1) ? 8'h00 : rx;
                            r.action = ACT_STORE;
                            r.cmd_index = store_pos[5:0];
                            r.cmd_byte = b;
                            store_pos++;
                            if (b == 8'h00) begin
                                r.cmd_done = 1'b1;
                                cmd_full = 1'b1;
                                link_phase = LINK_IDLE;
                            end
                        end
                    end
                    default: begin
                        link_phase = LINK_IDLE;
                        if (rx == FLOW_M2S) begin
                            link_phase = LINK_CONTENT;
                        end else if (rx == FLOW_S2M) begin
                            if (pend_flags[0]) begin
                                chosen_buf = CHOSEN_CMD;
                                r.tx_byte = ID_CMD;
                            end else if (pend_flags[1]) begin
                                chosen_buf = CHOSEN_LOG;
                                r.tx_byte = ID_LOG;
                            end else if (pend_flags[2]) begin
                                chosen_buf = CHOSEN_PROC;
                                r.tx_byte = ID_PROC;
                            end else begin
                                chosen_buf = CHOSEN_NONE;
                                r.tx_byte = ID_NONE;
                            end
                            r.action = ACT_SEND;
                            link_phase = LINK_ID_WAIT;
                        end
                    end
                endcase
            end
        endcase
        r.pending = pend_flags;
        r.cmd_full = cmd_full;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got, want);
        mismatch_count++;
    endtask

    // Drives one word in bursts with random gaps and returns at the edge that accepts it.
    task automatic send_word(t_op op, logic [7:0] rx, logic [2:0] mask,
                             bit typed = 1'b0, t_link_res typed_res = LINK_RES_NONE);
        t_link_res r;
        if (burst_left == 0) begin
            if (gap_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            gap_on = ($urandom_range(0, 7) != 0);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_rx_byte <= rx;
        i_post_mask <= mask;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = link_predict(op, rx, mask);
        expected_q.push_back(typed ? typed_res : r);
        words_sent++;
    endtask

    // Receiver stall pattern: modes of random length, one of them never stalls.
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
            stall_tick <= 0;
        end else begin
            stall_tick <= stall_tick + 1;
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(32, 256);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= (stall_tick[2:0] >= 3'd5);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_link_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result words", 1, 0);
            end else begin
                want = expected_q.pop_front();
                if (o_action != want.action) report_mismatch("action", o_action, want.action);
                if (o_tx_byte != want.tx_byte) report_mismatch("tx_byte", o_tx_byte, want.tx_byte);
                if (o_buffer_sel != want.buffer_sel)
                    report_mismatch("buffer_sel", o_buffer_sel, want.buffer_sel);
                if (o_cmd_index != want.cmd_index)
                    report_mismatch("cmd_index", o_cmd_index, want.cmd_index);
                if (o_cmd_byte != want.cmd_byte)
                    report_mismatch("cmd_byte", o_cmd_byte, want.cmd_byte);
                if (o_cmd_done != want.cmd_done)
                    report_mismatch("cmd_done", o_cmd_done, want.cmd_done);
                if (o_out_pending != want.pending)
                    report_mismatch("out_pending", o_out_pending, want.pending);
                if (o_in_cmd_full != want.cmd_full)
                    report_mismatch("in_cmd_full", o_in_cmd_full, want.cmd_full);
            end
        end
    end

    initial begin
        int row;
        int k;
        int cmd_len;
        int scenario;
        int drain;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < 25; row++)
            send_word(dir_rows[row].op, dir_rows[row].rx_byte, dir_rows[row].post_mask,
                      dir_rows[row].typed, dir_rows[row].res);

        while (words_sent < 25 + RANDOM_WORDS) begin
            scenario = $urandom_range(0, 9);
            if (scenario < 4) begin
                // Slave-to-master transfer, now and then with a stray word inside.
                if ($urandom_range(0, 1))
                    send_word(OP_POST, 8'($urandom), 3'($urandom_range(0, 7)));
                send_word(OP_RX_BYTE, FLOW_S2M, 3'($urandom));
                if ($urandom_range(0, 4) == 0)
                    send_word(t_op'($urandom_range(0, 3)), 8'($urandom), 3'($urandom));
                send_word(OP_TX_DONE, 8'($urandom), 3'($urandom));
                if ($urandom_range(0, 4) == 0)
                    send_word(OP_RX_BYTE, 8'($urandom), 3'($urandom));
                send_word(OP_TX_DONE, 8'($urandom), 3'($urandom));
            end else if (scenario < 7) begin
                // Master-to-slave command; a few run past the end of the store.
                if ($urandom_range(0, 9) < 7)
                    send_word(OP_RELEASE, 8'($urandom), 3'($urandom));
                send_word(OP_RX_BYTE, FLOW_M2S, 3'($urandom));
                send_word(OP_RX_BYTE,
                          ($urandom_range(0, 9) == 0) ? 8'($urandom) : CONTENT_CMD,
                          3'($urandom));
                cmd_len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                                        : $urandom_range(0, 8);
                for (k = 0; k < cmd_len; k++)
                    send_word(OP_RX_BYTE, 8'($urandom_range(1, 255)), 3'($urandom));
                send_word(OP_RX_BYTE, 8'h00, 3'($urandom));
            end else begin
                send_word(t_op'($urandom_range(0, 3)), 8'($urandom), 3'($urandom));
            end
        end

        i_in_valid <= 1'b0;
        drain = 0;
        while (expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            report_mismatch("missing result words", expected_q.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/slr_pkg.sv
design/slr_front.sv
design/slr_back.sv
design/single_wire_link_responder.sv
design/slr_checker.sv
tb/tb.sv
